// ===== rtl/fqia_pkg.sv =====
// Package for the indexed-access FIFO queue: sizes, command and status
// codes, beat types and controller state. No dependencies.
package fqia_pkg;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned VALUE_WIDTH = 64;
  localparam int unsigned IDX_W       = $clog2(DEPTH);
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W      = 64;
  localparam int unsigned POS_W       = 4;

  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_GET  = 2'd2,
    CMD_SWAP = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [DATA_W-1:0] value;
    logic [POS_W-1:0]  index_a;
    logic [POS_W-1:0]  index_b;
  } in_beat_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [1:0]        status;
    logic [4:0]        fill_count;
  } out_beat_t;

endpackage

// ===== rtl/fqia_ram.sv =====
// Generic true dual-port RAM, registered read per port.
// No dependencies.
module fqia_ram #(
  parameter int unsigned DEPTH_P = 16,
  parameter int unsigned WIDTH_P = 64
) (
  input  logic                       clk_i,
  input  logic                       a_en_i,
  input  logic                       a_we_i,
  input  logic [$clog2(DEPTH_P)-1:0] a_addr_i,
  input  logic [WIDTH_P-1:0]         a_wdata_i,
  output logic [WIDTH_P-1:0]         a_rdata_o,
  input  logic                       b_en_i,
  input  logic                       b_we_i,
  input  logic [$clog2(DEPTH_P)-1:0] b_addr_i,
  input  logic [WIDTH_P-1:0]         b_wdata_i,
  output logic [WIDTH_P-1:0]         b_rdata_o
);

  logic [WIDTH_P-1:0] mem [DEPTH_P];

  always_ff @(posedge clk_i) begin
    if (a_en_i) begin
      if (a_we_i) begin
        mem[a_addr_i] <= a_wdata_i;
      end else begin
        a_rdata_o <= mem[a_addr_i];
      end
    end
    if (b_en_i) begin
      if (b_we_i) begin
        mem[b_addr_i] <= b_wdata_i;
      end else begin
        b_rdata_o <= mem[b_addr_i];
      end
    end
  end

endmodule

// ===== rtl/fifo_queue_with_indexed_access.sv =====
// FIFO queue with indexed get and swap, entries in a dual-port ring RAM.
// Depends on fqia_pkg and fqia_ram.
//
//   channel | direction | handshake                  | beat
//   in      | input     | in_valid_i / in_stall_o    | in_beat_t  (cmd, value, index_a/b)
//   out     | output    | out_valid_o / out_stall_i  | out_beat_t (data, status, fill_count)
//
// Every command runs in two states: the accept in S_IDLE reads both RAM ports,
// then S_EXEC writes back (enqueue, swap) and loads the output register.
// A waiting result holds S_EXEC until the output register frees.
// Reset clears head, count and handshake state; RAM contents are not cleared.
// A new beat is accepted while the previous result still waits downstream.
module fifo_queue_with_indexed_access
  import fqia_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  state_e state_q, state_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;
  cmd_e             cmd_q;
  logic             ok_q, ok_d;
  logic [VALUE_WIDTH-1:0] word_q;
  logic [IDX_W-1:0] slot_a_q, slot_b_q, slot_a_d, slot_b_d;
  logic             out_valid_q;
  out_beat_t        out_data_q, res;

  logic accept, exec_go;
  logic a_en, a_we, b_en, b_we;
  logic [IDX_W-1:0] a_addr, b_addr;
  logic [VALUE_WIDTH-1:0] a_wdata, b_wdata, a_rdata, b_rdata;
  logic ia_in, ib_in;

  assign accept  = in_valid_i && !in_stall_o;
  assign exec_go = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = S_EXEC;
      S_EXEC: if (exec_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != S_IDLE);
  end

  // slot decode and command check at accept
  always_comb begin
    ia_in    = CNT_W'(in_data_i.index_a) < count_q;
    ib_in    = CNT_W'(in_data_i.index_b) < count_q;
    slot_a_d = head_q + IDX_W'(in_data_i.index_a);
    slot_b_d = head_q + IDX_W'(in_data_i.index_b);
    ok_d     = 1'b0;
    case (in_data_i.cmd)
      CMD_ENQ: begin
        slot_a_d = head_q + count_q[IDX_W-1:0];
        ok_d     = (count_q != CNT_W'(DEPTH));
      end
      CMD_DEQ: begin
        slot_a_d = head_q;
        ok_d     = (count_q != '0);
      end
      CMD_GET:  ok_d = ia_in;
      CMD_SWAP: ok_d = ia_in && ib_in && (in_data_i.index_a != in_data_i.index_b);
      default:  ok_d = 1'b0;
    endcase
  end

  always_comb begin
    a_we    = exec_go && ok_q && (cmd_q == CMD_ENQ || cmd_q == CMD_SWAP);
    b_we    = exec_go && ok_q && (cmd_q == CMD_SWAP);
    a_en    = accept || a_we;
    b_en    = accept || b_we;
    a_addr  = (state_q == S_IDLE) ? slot_a_d : slot_a_q;
    b_addr  = (state_q == S_IDLE) ? slot_b_d : slot_b_q;
    a_wdata = (cmd_q == CMD_ENQ) ? word_q : b_rdata;
    b_wdata = a_rdata;
  end

  fqia_ram #(
    .DEPTH_P(DEPTH),
    .WIDTH_P(VALUE_WIDTH)
  ) u_ram (
    .clk_i    (clk_i),
    .a_en_i   (a_en),
    .a_we_i   (a_we),
    .a_addr_i (a_addr),
    .a_wdata_i(a_wdata),
    .a_rdata_o(a_rdata),
    .b_en_i   (b_en),
    .b_we_i   (b_we),
    .b_addr_i (b_addr),
    .b_wdata_i(b_wdata),
    .b_rdata_o(b_rdata)
  );

  // result and pointer update
  always_comb begin
    head_d         = head_q;
    count_d        = count_q;
    res.data       = '0;
    res.status     = ST_OK;
    case (cmd_q)
      CMD_ENQ: begin
        if (ok_q) count_d = count_q + CNT_W'(1);
        else res.status = ST_FULL;
      end
      CMD_DEQ: begin
        if (ok_q) begin
          head_d   = head_q + IDX_W'(1);
          count_d  = count_q - CNT_W'(1);
          res.data = DATA_W'(a_rdata);
        end else begin
          res.status = ST_RANGE;
        end
      end
      CMD_GET: begin
        if (ok_q) res.data = DATA_W'(a_rdata);
        else res.status = ST_RANGE;
      end
      default: res.status = ST_OK;
    endcase
    res.fill_count = 5'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (exec_go) begin
        head_q  <= head_d;
        count_q <= count_d;
      end
      if (exec_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= in_data_i.cmd;
      ok_q     <= ok_d;
      word_q   <= in_data_i.value[VALUE_WIDTH-1:0];
      slot_a_q <= slot_a_d;
      slot_b_q <= slot_b_d;
    end
    if (exec_go) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_FULL |-> out_data_o.fill_count == 5'(DEPTH))
    else $error("full status with free entries");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_EXEC && !accept)
    else $error("accept did not start execution");

  a_ptr_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(exec_go) |-> $stable(head_q) && $stable(count_q))
    else $error("pointers moved outside execution");

endmodule
